// ===== src/far_pkg.sv =====
// Shared types and constants for the fraction add and reduce block.
package far_pkg;

   localparam int DEFAULT_FIELD_WIDTH = 16;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MULT,
      ST_ADD,
      ST_INIT,
      ST_GCD,
      ST_DIV,
      ST_HOLD
   } far_state_type;

   typedef struct packed {
      logic load_in;
      logic mult;
      logic add;
      logic init;
      logic gcd_step;
      logic div_load;
      logic div_step;
      logic load_out;
   } far_cmd_type;

   typedef struct packed {
      logic special;
      logic gcd_done;
      logic div_done;
      logic out_free;
   } far_status_type;

endpackage

// ===== src/far_ctrl.sv =====
// Controller state machine that sequences the fraction add and reduce datapath.
module far_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  far_pkg::far_status_type status,
   output far_pkg::far_cmd_type    cmd
);

   far_pkg::far_state_type state_ff;
   far_pkg::far_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= far_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         far_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load_in = 1'b1;
               state_in    = far_pkg::ST_MULT;
            end
         end
         far_pkg::ST_MULT: begin
            cmd.mult = 1'b1;
            state_in = far_pkg::ST_ADD;
         end
         far_pkg::ST_ADD: begin
            cmd.add  = 1'b1;
            state_in = far_pkg::ST_INIT;
         end
         far_pkg::ST_INIT: begin
            if (status.special) begin
               state_in = far_pkg::ST_HOLD;
            end else begin
               cmd.init = 1'b1;
               state_in = far_pkg::ST_GCD;
            end
         end
         far_pkg::ST_GCD: begin
            if (status.gcd_done) begin
               cmd.div_load = 1'b1;
               state_in     = far_pkg::ST_DIV;
            end else begin
               cmd.gcd_step = 1'b1;
            end
         end
         far_pkg::ST_DIV: begin
            if (status.div_done) begin
               state_in = far_pkg::ST_HOLD;
            end else begin
               cmd.div_step = 1'b1;
            end
         end
         far_pkg::ST_HOLD: begin
            if (status.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = far_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = far_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

// ===== src/far_datapath.sv =====
// Datapath with multipliers, binary gcd unit, twin dividers and the output register.
module far_datapath #(
   parameter int FIELD_WIDTH = far_pkg::DEFAULT_FIELD_WIDTH
) (
   input  logic                          clock,
   input  logic                          reset,
   input  far_pkg::far_cmd_type          cmd,
   output far_pkg::far_status_type       status,
   input  logic signed [FIELD_WIDTH-1:0] req_first_num,
   input  logic        [FIELD_WIDTH-2:0] req_first_den,
   input  logic signed [FIELD_WIDTH-1:0] req_second_num,
   input  logic        [FIELD_WIDTH-2:0] req_second_den,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [2*FIELD_WIDTH-1:0] rsp_sum_num,
   output logic        [2*FIELD_WIDTH-3:0] rsp_sum_den
);

   localparam int W  = FIELD_WIDTH;
   localparam int NW = 2 * FIELD_WIDTH - 1;
   localparam int CW = $clog2(NW + 1);

   logic signed [W-1:0]    n1_ff, n2_ff;
   logic        [W-2:0]    d1_ff, d2_ff;
   logic signed [2*W-1:0]  prod1_ff, prod2_ff;
   logic        [2*W-3:0]  den_ff;
   logic signed [2*W-1:0]  num_ff;
   logic                   neg_ff;
   logic        [NW-1:0]   a_ff, b_ff, mag_s_ff, den_s_ff;
   logic        [NW-1:0]   qa_ff, qb_ff, ra_ff, rb_ff;
   logic        [CW-1:0]   cnt_ff;
   logic                   rsp_valid_ff;
   logic signed [2*W-1:0]  out_num_ff;
   logic        [2*W-3:0]  out_den_ff;

   logic signed [W-1:0]    d1_s, d2_s;
   logic signed [2*W-1:0]  mag_full;
   logic        [NW:0]     ta, tb;
   logic                   ga, gb;
   logic        [2*W-1:0]  qa_ext;

   assign d1_s     = {1'b0, d1_ff};
   assign d2_s     = {1'b0, d2_ff};
   assign mag_full = num_ff[2*W-1] ? -num_ff : num_ff;

   assign ta = {ra_ff, qa_ff[NW-1]};
   assign tb = {rb_ff, qb_ff[NW-1]};
   assign ga = ta >= {1'b0, a_ff};
   assign gb = tb >= {1'b0, a_ff};
   assign qa_ext = {1'b0, qa_ff};

   always_ff @(posedge clock) begin
      if (cmd.load_in) begin
         n1_ff <= req_first_num;
         d1_ff <= req_first_den;
         n2_ff <= req_second_num;
         d2_ff <= req_second_den;
      end
      if (cmd.mult) begin
         prod1_ff <= n1_ff * d2_s;
         prod2_ff <= n2_ff * d1_s;
         den_ff   <= d1_ff * d2_ff;
      end
      if (cmd.add) begin
         num_ff <= prod1_ff + prod2_ff;
      end
      if (cmd.init) begin
         neg_ff   <= num_ff[2*W-1];
         a_ff     <= mag_full[NW-1:0];
         b_ff     <= {1'b0, den_ff};
         mag_s_ff <= mag_full[NW-1:0];
         den_s_ff <= {1'b0, den_ff};
      end else if (cmd.gcd_step) begin
         priority if (!a_ff[0] && !b_ff[0]) begin
            a_ff     <= a_ff >> 1;
            b_ff     <= b_ff >> 1;
            mag_s_ff <= mag_s_ff >> 1;
            den_s_ff <= den_s_ff >> 1;
         end else if (!a_ff[0]) begin
            a_ff <= a_ff >> 1;
         end else if (!b_ff[0]) begin
            b_ff <= b_ff >> 1;
         end else if (a_ff > b_ff) begin
            a_ff <= (a_ff - b_ff) >> 1;
         end else begin
            b_ff <= (b_ff - a_ff) >> 1;
         end
      end
      if (cmd.div_load) begin
         qa_ff  <= mag_s_ff;
         qb_ff  <= den_s_ff;
         ra_ff  <= '0;
         rb_ff  <= '0;
         cnt_ff <= CW'(NW);
      end else if (cmd.div_step) begin
         qa_ff  <= {qa_ff[NW-2:0], ga};
         qb_ff  <= {qb_ff[NW-2:0], gb};
         ra_ff  <= ga ? NW'(ta - {1'b0, a_ff}) : ta[NW-1:0];
         rb_ff  <= gb ? NW'(tb - {1'b0, a_ff}) : tb[NW-1:0];
         cnt_ff <= cnt_ff - 1'b1;
      end
      if (cmd.load_out) begin
         priority if (den_ff == '0) begin
            out_num_ff <= '0;
            out_den_ff <= '0;
         end else if (num_ff == '0) begin
            out_num_ff <= '0;
            out_den_ff <= (2*W-2)'(1);
         end else begin
            out_num_ff <= neg_ff ? -qa_ext : qa_ext;
            out_den_ff <= qb_ff[2*W-3:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign status.special  = (den_ff == '0) || (num_ff == '0);
   assign status.gcd_done = a_ff == b_ff;
   assign status.div_done = cnt_ff == '0;
   assign status.out_free = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_sum_num = out_num_ff;
   assign rsp_sum_den = out_den_ff;

endmodule

// ===== src/fraction_add_reduce_core.sv =====
// Top level of the fraction add and reduce block: controller plus datapath.
//
//   channel  direction  handshake          payload
//   req      in         req_valid/stall    first_num, first_den, second_num, second_den
//   rsp      out        rsp_valid/stall    sum_num, sum_den
//
// A transaction forms the products, the sum and the setup, then runs the binary gcd
// loop at one subtract or shift per cycle, then the two restoring dividers, then
// loads the output register; a zero sum or a zero denominator skips gcd and dividers.
// Reset is synchronous and clears the controller and the output valid flag.
// The next request transaction is taken while a result waits in the output
// register; a stalled result holds the block only when the following one is done.
module fraction_add_reduce_core #(
   parameter int FIELD_WIDTH = far_pkg::DEFAULT_FIELD_WIDTH
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic signed [FIELD_WIDTH-1:0]   req_first_num,
   input  logic        [FIELD_WIDTH-2:0]   req_first_den,
   input  logic signed [FIELD_WIDTH-1:0]   req_second_num,
   input  logic        [FIELD_WIDTH-2:0]   req_second_den,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic signed [2*FIELD_WIDTH-1:0] rsp_sum_num,
   output logic        [2*FIELD_WIDTH-3:0] rsp_sum_den
);

   far_pkg::far_cmd_type    cmd;
   far_pkg::far_status_type status;

   far_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   far_datapath #(
      .FIELD_WIDTH (FIELD_WIDTH)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_first_num  (req_first_num),
      .req_first_den  (req_first_den),
      .req_second_num (req_second_num),
      .req_second_den (req_second_den),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_sum_num    (rsp_sum_num),
      .rsp_sum_den    (rsp_sum_den)
   );

endmodule

// ===== sim/far_sum_checker.sv =====
// Checker that predicts the reduced sum of every request transaction and compares responses.
`timescale 1ns / 100ps
module far_sum_checker #(
   parameter int FIELD_WIDTH = far_pkg::DEFAULT_FIELD_WIDTH
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_stall,
   input  logic signed [FIELD_WIDTH-1:0]   req_first_num,
   input  logic        [FIELD_WIDTH-2:0]   req_first_den,
   input  logic signed [FIELD_WIDTH-1:0]   req_second_num,
   input  logic        [FIELD_WIDTH-2:0]   req_second_den,
   input  logic                            rsp_valid,
   input  logic                            rsp_stall,
   input  logic signed [2*FIELD_WIDTH-1:0] rsp_sum_num,
   input  logic        [2*FIELD_WIDTH-3:0] rsp_sum_den,
   output int                              error_count,
   output int                              sums_pending
);

   typedef struct packed {
      logic signed [2*FIELD_WIDTH-1:0] num;
      logic        [2*FIELD_WIDTH-3:0] den;
   } reduced_sum_type;

   reduced_sum_type expected_sums[$];
   reduced_sum_type oldest_sum;

   function automatic reduced_sum_type reduced_sum(
      input logic signed [FIELD_WIDTH-1:0] n1,
      input logic        [FIELD_WIDTH-2:0] d1,
      input logic signed [FIELD_WIDTH-1:0] n2,
      input logic        [FIELD_WIDTH-2:0] d2
   );
      longint          cross_sum;
      longint unsigned den_product;
      longint unsigned magnitude;
      longint unsigned a;
      longint unsigned b;
      longint unsigned r;
      reduced_sum_type result;
      result.num = '0;
      result.den = '0;
      den_product = longint'(d1) * longint'(d2);
      cross_sum = longint'(n1) * longint'(d2) + longint'(n2) * longint'(d1);
      // A zero denominator yields the error code 0/0.
      if (den_product == 0)
         return result;
      if (cross_sum == 0) begin
         result.den = (2*FIELD_WIDTH-2)'(1);
         return result;
      end
      magnitude = (cross_sum < 0) ? -cross_sum : cross_sum;
      a = magnitude;
      b = den_product;
      while (b != 0) begin
         r = a % b;
         a = b;
         b = r;
      end
      magnitude = magnitude / a;
      result.num = (2*FIELD_WIDTH)'((cross_sum < 0) ? -magnitude : magnitude);
      result.den = (2*FIELD_WIDTH-2)'(den_product / a);
      return result;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         expected_sums.delete();
      end else begin
         if (req_valid && !req_stall)
            expected_sums.push_back(reduced_sum(req_first_num, req_first_den,
                                                req_second_num, req_second_den));
         if (rsp_valid && !rsp_stall) begin
            if (expected_sums.size() == 0) begin
               $error("Unexpected response transaction: sum_num %0d, sum_den %0d",
                      rsp_sum_num, rsp_sum_den);
               error_count++;
            end else begin
               oldest_sum = expected_sums.pop_front();
               if (rsp_sum_num !== oldest_sum.num) begin
                  $error("sum_num: expected %0d, got %0d", oldest_sum.num, rsp_sum_num);
                  error_count++;
               end
               if (rsp_sum_den !== oldest_sum.den) begin
                  $error("sum_den: expected %0d, got %0d", oldest_sum.den, rsp_sum_den);
                  error_count++;
               end
            end
         end
      end
      sums_pending = expected_sums.size();
   end

endmodule

// ===== sim/tb_fraction_add_reduce_core.sv =====
// Testbench top for the fraction add and reduce block: stimulus, response stalls and verdict.
`timescale 1ns / 100ps
module tb_fraction_add_reduce_core;

   localparam int W = far_pkg::DEFAULT_FIELD_WIDTH;
   localparam int RANDOM_ITEMS = 1100;
   localparam logic signed [W-1:0] NUM_MIN = {1'b1, {(W-1){1'b0}}};
   localparam logic signed [W-1:0] NUM_MAX = {1'b0, {(W-1){1'b1}}};
   localparam logic [W-2:0] DEN_MAX = {(W-1){1'b1}};
   localparam logic [W-2:0] DEN_MAX_LESS = DEN_MAX - (W-1)'(1);

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic signed [W-1:0]   req_first_num = '0;
   logic        [W-2:0]   req_first_den = '0;
   logic signed [W-1:0]   req_second_num = '0;
   logic        [W-2:0]   req_second_den = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic signed [2*W-1:0] rsp_sum_num;
   logic        [2*W-3:0] rsp_sum_den;
   int                    error_count;
   int                    sums_pending;

   int burst_left = 0;
   int stall_mode = 0;
   int stall_left = 0;
   int stall_phase = 0;

   fraction_add_reduce_core #(.FIELD_WIDTH(W)) dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_first_num  (req_first_num),
      .req_first_den  (req_first_den),
      .req_second_num (req_second_num),
      .req_second_den (req_second_den),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_sum_num    (rsp_sum_num),
      .rsp_sum_den    (rsp_sum_den)
   );

   far_sum_checker #(.FIELD_WIDTH(W)) sum_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_first_num  (req_first_num),
      .req_first_den  (req_first_den),
      .req_second_num (req_second_num),
      .req_second_den (req_second_den),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_sum_num    (rsp_sum_num),
      .rsp_sum_den    (rsp_sum_den),
      .error_count    (error_count),
      .sums_pending   (sums_pending)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // The receiver switches between stretches of no stalls, random stalls,
   // a fixed stall rhythm and near-constant stalls.
   always @(posedge clock) begin
      stall_phase <= stall_phase + 1;
      if (stall_left == 0) begin
         stall_mode <= $urandom_range(0, 3);
         stall_left <= $urandom_range(50, 600);
      end else begin
         stall_left <= stall_left - 1;
      end
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 1) == 1);
         2: rsp_stall <= ((stall_phase % 9) < 5);
         default: rsp_stall <= ($urandom_range(0, 15) != 0);
      endcase
   end

   task automatic send_fractions(
      input logic signed [W-1:0] n1,
      input logic        [W-2:0] d1,
      input logic signed [W-1:0] n2,
      input logic        [W-2:0] d2
   );
      int   gap;
      int   roll;
      logic taken;
      if (burst_left == 0) begin
         roll = $urandom_range(0, 9);
         if (roll < 6)
            gap = $urandom_range(0, 3);
         else if (roll < 9)
            gap = $urandom_range(1, 40);
         else
            gap = $urandom_range(40, 200);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      req_valid <= 1'b1;
      req_first_num <= n1;
      req_first_den <= d1;
      req_second_num <= n2;
      req_second_den <= d2;
      taken = 1'b0;
      while (!taken) begin
         @(negedge clock);
         taken = !req_stall;
         @(posedge clock);
      end
   endtask

   function automatic logic signed [W-1:0] extreme_num();
      case ($urandom_range(0, 4))
         0: return NUM_MIN;
         1: return -1;
         2: return 0;
         3: return 1;
         default: return NUM_MAX;
      endcase
   endfunction

   task automatic send_random_fractions();
      int                  kind;
      int                  factor;
      logic signed [W-1:0] n1;
      logic signed [W-1:0] n2;
      logic        [W-2:0] d1;
      logic        [W-2:0] d2;
      kind = $urandom_range(0, 19);
      n1 = W'($urandom);
      n2 = W'($urandom);
      d1 = (W-1)'($urandom_range(1, DEN_MAX));
      d2 = (W-1)'($urandom_range(1, DEN_MAX));
      if (kind >= 9 && kind <= 12) begin
         n1 = W'(int'($urandom_range(0, 40)) - 20);
         n2 = W'(int'($urandom_range(0, 40)) - 20);
         d1 = (W-1)'($urandom_range(1, 24));
         d2 = (W-1)'($urandom_range(1, 24));
      end else if (kind >= 13 && kind <= 15) begin
         factor = $urandom_range(2, 60);
         n1 = W'(factor * (int'($urandom_range(0, 400)) - 200));
         n2 = W'(factor * (int'($urandom_range(0, 400)) - 200));
         d1 = (W-1)'(factor * int'($urandom_range(1, 500)));
         d2 = (W-1)'(factor * int'($urandom_range(1, 500)));
      end else if (kind == 16) begin
         n1 = extreme_num();
         n2 = extreme_num();
         d1 = $urandom_range(0, 1) ? DEN_MAX : (W-1)'(1);
         d2 = $urandom_range(0, 1) ? DEN_MAX : (W-1)'(1);
      end else if (kind == 17) begin
         n2 = -n1;
         d2 = d1;
      end else if (kind == 18) begin
         if ($urandom_range(0, 1))
            d1 = 0;
         else
            d2 = 0;
      end else if (kind == 19) begin
         d2 = d1;
      end
      send_fractions(n1, d1, n2, d2);
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      send_fractions(0, 1, 0, 1);
      send_fractions(1, 2, 1, 2);
      send_fractions(-1, 3, 1, 3);
      send_fractions(3, 4, -5, 6);
      send_fractions(-7, 1, 2, 1);
      send_fractions(NUM_MIN, 1, NUM_MIN, 1);
      send_fractions(NUM_MAX, 1, NUM_MAX, 1);
      send_fractions(NUM_MAX, DEN_MAX, NUM_MAX, DEN_MAX);
      send_fractions(NUM_MIN, DEN_MAX, NUM_MAX, DEN_MAX);
      send_fractions(NUM_MIN, DEN_MAX, NUM_MIN, DEN_MAX_LESS);
      send_fractions(NUM_MAX, DEN_MAX, NUM_MIN, 1);
      send_fractions(1, DEN_MAX, 1, DEN_MAX_LESS);
      send_fractions(-1, DEN_MAX, -1, DEN_MAX);
      send_fractions(5, 0, 1, 2);
      send_fractions(1, 2, 3, 0);
      send_fractions(0, 0, 0, 0);
      send_fractions(NUM_MIN, 0, NUM_MAX, DEN_MAX);
      send_fractions(6, 4, 9, 6);

      repeat (RANDOM_ITEMS) send_random_fractions();

      req_valid <= 1'b0;
      @(negedge clock);
      while (sums_pending != 0) @(negedge clock);
      repeat (200) @(posedge clock);
      if (error_count == 0 && sums_pending == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

   initial begin
      #10000000;
      $display("FAIL");
      $finish;
   end

endmodule

// ===== fraction_add_reduce_core.f =====
src/far_pkg.sv
src/far_ctrl.sv
src/far_datapath.sv
src/fraction_add_reduce_core.sv
sim/far_sum_checker.sv
sim/tb_fraction_add_reduce_core.sv
